// ----- sv/dra_pkg.sv -----
`timescale 1ns / 1ps

package dra_pkg;

    // Record layout: 4-byte offset, 4-byte length, little-endian
    localparam int HeaderBytes = 8;
    localparam int FieldBytes  = 4;
    localparam int HdrCntWidth = $clog2(HeaderBytes);

    // Default depth of the queue between parser and output stage
    localparam int QueueDepth = 4;

    // Configuration register indexes
    localparam int CfgIndexWidth = 1;
    localparam logic [CfgIndexWidth-1:0] CFG_BLOB_SIZE  = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CFG_DELTA_SIZE = 1'b1;

    typedef enum logic {
        KIND_NONE  = 1'b0,
        KIND_PATCH = 1'b1
    } kind_t;

    typedef struct packed {
        logic [31:0] blob_size;
        logic [31:0] delta_size;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [7:0]  mask;
        logic        done;
        logic        ok;
    } result_t;

endpackage

// ----- sv/dra_front.sv -----
`timescale 1ns / 1ps

module dra_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     delta_byte,
    input  logic           delta_valid,
    output logic           delta_ready,
    input  dra_pkg::cfg_t  cfg,
    output dra_pkg::result_t item,
    output logic           item_valid,
    input  logic           item_ready
);
    import dra_pkg::*;

    logic [31:0]            pos_reg,     pos_next;
    logic [HdrCntWidth-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]            offset_reg,  offset_next;
    logic [31:0]            length_reg,  length_next;
    logic [31:0]            remain_reg,  remain_next;
    logic [31:0]            waddr_reg,   waddr_next;
    logic                   error_reg,   error_next;

    logic        accept;
    logic [32:0] pos_ext;
    logic [32:0] pos_inc;
    logic        room_ok;
    logic [31:0] len_full;
    logic [33:0] span_delta;
    logic [32:0] span_blob;
    logic [31:0] field_base;
    logic [31:0] field_merged;
    logic        is_offset_byte;

    // Transfer straight into the queue
    assign accept      = delta_valid && item_ready;
    assign delta_ready = item_ready;
    assign item_valid  = delta_valid;

    // Position arithmetic and header checks
    assign pos_ext    = {1'b0, pos_reg};
    assign pos_inc    = pos_ext + 33'd1;
    assign room_ok    = (pos_ext + 33'(HeaderBytes)) <= {1'b0, cfg.delta_size};
    assign len_full   = {delta_byte, length_reg[23:0]};
    assign span_delta = {1'b0, pos_inc} + {2'b00, len_full};
    assign span_blob  = {1'b0, offset_reg} + {1'b0, len_full};

    // Place the header byte into its field lane
    assign is_offset_byte = (hdr_cnt_reg < HdrCntWidth'(FieldBytes));
    always_comb
    begin
        if (hdr_cnt_reg[1:0] == 2'd0)
        begin
            field_base = '0;
        end
        else if (is_offset_byte)
        begin
            field_base = offset_reg;
        end
        else
        begin
            field_base = length_reg;
        end
        field_merged = field_base;
        field_merged[8*hdr_cnt_reg[1:0] +: 8] = delta_byte;
    end

    // Parse one byte: payload, header, or drop after a fault
    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        waddr_next   = waddr_reg;
        error_next   = error_reg;
        pos_next     = (&pos_reg) ? pos_reg : pos_inc[31:0];

        item         = '0;
        item.kind    = KIND_NONE;
        item.address = waddr_reg;
        item.mask    = delta_byte;

        if (!error_reg)
        begin
            if (remain_reg != '0)
            begin
                item.kind   = KIND_PATCH;
                waddr_next  = waddr_reg + 32'd1;
                remain_next = remain_reg - 32'd1;
            end
            else if ((hdr_cnt_reg == '0) && !room_ok)
            begin
                error_next = 1'b1;
            end
            else
            begin
                if (is_offset_byte)
                begin
                    offset_next = field_merged;
                end
                else
                begin
                    length_next = field_merged;
                end

                if (hdr_cnt_reg == HdrCntWidth'(HeaderBytes - 1))
                begin
                    hdr_cnt_next = '0;
                    if ((span_delta > {2'b00, cfg.delta_size}) ||
                        (span_blob > {1'b0, cfg.blob_size}))
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        remain_next = len_full;
                        waddr_next  = offset_reg;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + HdrCntWidth'(1);
                end
            end
        end

        // Final byte of the stream reports the outcome
        item.done = (pos_inc == {1'b0, cfg.delta_size});
        item.ok   = item.done && !error_next && (hdr_cnt_next == '0) &&
                    (remain_next == '0);
    end

    // Advance parser state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hdr_cnt_reg <= '0;
            offset_reg  <= '0;
            length_reg  <= '0;
            remain_reg  <= '0;
            waddr_reg   <= '0;
            error_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            hdr_cnt_reg <= hdr_cnt_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            remain_reg  <= remain_next;
            waddr_reg   <= waddr_next;
            error_reg   <= error_next;
        end
    end

endmodule

// ----- sv/dra_queue.sv -----
`timescale 1ns / 1ps

module dra_queue #(
    parameter int DEPTH = dra_pkg::QueueDepth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dra_pkg::result_t push_data,
    input  logic             push_valid,
    output logic             push_ready,
    output dra_pkg::result_t pop_data,
    output logic             pop_valid,
    input  logic             pop_ready
);
    import dra_pkg::*;

    localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountWidth = $clog2(DEPTH + 1);

    result_t                entries [DEPTH];
    logic [PtrWidth-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0]  count_reg,  count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != CountWidth'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Wrap pointers at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0
                          : wr_ptr_reg + PtrWidth'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0
                          : rd_ptr_reg + PtrWidth'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CountWidth'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CountWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/dra_back.sv -----
`timescale 1ns / 1ps

module dra_back (
    input  logic             clk,
    input  logic             rst_n,
    input  dra_pkg::result_t item,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    output logic             patch_valid,
    output logic [31:0]      patch_address,
    output logic [7:0]       patch_mask,
    output logic             stream_done,
    output logic             stream_ok
);
    import dra_pkg::*;

    logic        valid_reg;
    logic        pvalid_reg,  pvalid_next;
    logic [31:0] address_reg, address_next;
    logic [7:0]  mask_reg,    mask_next;
    logic        done_reg;
    logic        ok_reg;
    logic        load;

    // Refill when the output register is empty or being drained
    assign item_ready = !valid_reg || result_ready;
    assign load       = item_valid && item_ready;

    // Decode the entry kind; only patches carry address and mask
    always_comb
    begin
        unique case (item.kind)
            KIND_PATCH:
            begin
                pvalid_next  = 1'b1;
                address_next = item.address;
                mask_next    = item.mask;
            end
            default:
            begin
                pvalid_next  = 1'b0;
                address_next = '0;
                mask_next    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pvalid_reg  <= pvalid_next;
            address_reg <= address_next;
            mask_reg    <= mask_next;
            done_reg    <= item.done;
            ok_reg      <= item.ok;
        end
    end

    assign result_valid  = valid_reg;
    assign patch_valid   = pvalid_reg;
    assign patch_address = address_reg;
    assign patch_mask    = mask_reg;
    assign stream_done   = done_reg;
    assign stream_ok     = ok_reg;

endmodule

// ----- sv/xor_delta_record_applier.sv -----
`timescale 1ns / 1ps

// XOR delta record applier.
// Input channel delta_valid/delta_ready carries one delta_byte per transfer.
// The stream is a run of records: 4-byte little-endian offset, 4-byte
// little-endian length, then that many XOR bytes. Each input byte yields
// exactly one result on result_valid/result_ready: patch_valid with
// patch_address and patch_mask for a payload byte, and stream_done with
// stream_ok on the byte at position delta_size - 1.
// A record that runs past delta_size or blob_size, or a header that starts
// with fewer than 8 bytes left, latches an error: no more patches follow.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is blob_size, index 1 is delta_size. Write it while idle.
// An input byte is written into the queue at its input transfer, and the output
// register then loads it from the queue, which raises result_valid.
// Throughput is one byte per cycle while the receiver keeps result_ready high;
// the header add/compare in the parser is combinational.
// When the receiver stalls, the queue absorbs up to QUEUE_DEPTH bytes plus
// the output register before delta_ready drops.
// Reset clears stream position, header state, error flag and both registers.
module xor_delta_record_applier #(
    parameter int QUEUE_DEPTH = dra_pkg::QueueDepth
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                delta_valid,
    output logic                                delta_ready,
    input  logic [7:0]                          delta_byte,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                patch_valid,
    output logic [31:0]                         patch_address,
    output logic [7:0]                          patch_mask,
    output logic                                stream_done,
    output logic                                stream_ok,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dra_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [31:0]                         cfg_data
);
    import dra_pkg::*;

    cfg_t    cfg_reg;
    result_t front_item;
    logic    front_valid;
    logic    front_ready;
    result_t queue_item;
    logic    queue_valid;
    logic    queue_ready;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BLOB_SIZE:  cfg_reg.blob_size  <= cfg_data;
                CFG_DELTA_SIZE: cfg_reg.delta_size <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    dra_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .delta_byte  (delta_byte),
        .delta_valid (delta_valid),
        .delta_ready (delta_ready),
        .cfg         (cfg_reg),
        .item        (front_item),
        .item_valid  (front_valid),
        .item_ready  (front_ready)
    );

    dra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (queue_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    dra_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (queue_item),
        .item_valid    (queue_valid),
        .item_ready    (queue_ready),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .patch_valid   (patch_valid),
        .patch_address (patch_address),
        .patch_mask    (patch_mask),
        .stream_done   (stream_done),
        .stream_ok     (stream_ok)
    );

`ifndef SYNTHESIS
    // Success is only ever reported on the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!stream_ok || stream_done))
        else $error("stream_ok without stream_done");

    // Non-patch results carry a zero address and mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !patch_valid) |-> ((patch_address == '0) && (patch_mask == '0)))
        else $error("non-patch result carries address or mask");

    // A result taken with the queue holding data is followed by another result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && queue_valid) |=> result_valid)
        else $error("output register not refilled from queue");
`endif

endmodule
